// ----- design/ncc_pkg.sv -----
// shared types and constants for the nucleotide composition counter
package ncc_pkg;

	localparam int NUM_LANES = 4;
	localparam int NUM_CLASSES = 6;
	localparam int INCR_BITS = 3;
	localparam int GAP_BITS = 32;
	localparam int OUT_BITS = 32;

	// class slots of the per-code hit vector and of the counter array
	localparam int CLS_A = 0;
	localparam int CLS_C = 1;
	localparam int CLS_G = 2;
	localparam int CLS_T = 3;
	localparam int CLS_N = 4;
	localparam int CLS_OTHER = 5;

	typedef enum logic [1:0] {
		REQ_DATA   = 2'd0,
		REQ_GAP    = 2'd1,
		REQ_REF    = 2'd2,
		REQ_FINISH = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ENC_IUPAC = 2'd0,
		ENC_TWO   = 2'd1,
		ENC_FOUR  = 2'd2,
		ENC_NONE  = 2'd3
	} enc_e_t;

	// packed 2-bit codes
	localparam logic [1:0] TWO_A = 2'd0;
	localparam logic [1:0] TWO_C = 2'd1;
	localparam logic [1:0] TWO_G = 2'd2;
	localparam logic [1:0] TWO_T = 2'd3;

	// packed 4-bit codes
	localparam logic [3:0] NIB_A = 4'd1;
	localparam logic [3:0] NIB_C = 4'd2;
	localparam logic [3:0] NIB_G = 4'd4;
	localparam logic [3:0] NIB_T = 4'd8;
	localparam logic [3:0] NIB_N = 4'd15;

	// upper-case letters
	localparam logic [7:0] LETTER_A = 8'h41;
	localparam logic [7:0] LETTER_C = 8'h43;
	localparam logic [7:0] LETTER_G = 8'h47;
	localparam logic [7:0] LETTER_T = 8'h54;
	localparam logic [7:0] LETTER_N = 8'h4E;

	typedef logic [NUM_CLASSES-1:0] class_hit_t;

	typedef struct packed {
		logic used;
		logic first_n;
		logic last_n;
		logic [NUM_CLASSES-1:0][INCR_BITS-1:0] incr;
	} data_info_t;

	typedef struct packed {
		req_e_t req;
		data_info_t data;
		logic [GAP_BITS-1:0] gap_length;
	} stage_item_t;

	typedef struct packed {
		logic begins_gap;
		logic finishes_gap;
		logic saw_reference;
	} summary_flags_t;

	// number of codes one byte holds in each encoding
	function automatic logic [2:0] codes_per_byte(enc_e_t enc);
		logic [2:0] n;
		unique case (enc)
			ENC_IUPAC: n = 3'd1;
			ENC_TWO:   n = 3'd4;
			ENC_FOUR:  n = 3'd2;
			ENC_NONE:  n = 3'd0;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- design/nucleotide_composition_counter.sv -----
// top level of the nucleotide composition counter
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid, in_stall, req_type, encoding, data_byte,  | into block
//          | symbol_count, gap_length                           |
//  out     | out_valid, out_stall, count_a .. count_other,      | out of block
//          | gap_total, starts_with_gap, ends_with_gap,         |
//          | has_reference                                      |
//
// one item per cycle while in_stall is low; an item passes the decode stage
// (four lanes plus merge) and is folded into the counters as it retires from it
// a finish item loads its summary into the output register as it retires
// reset clears the counters, flags and both valid bits; payload is not reset
// in_stall rises only when a finish item waits in the decode stage while the
// output register still holds an untaken summary
module nucleotide_composition_counter #(
	parameter int COUNT_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic [1:0]                   encoding,
	input  logic [7:0]                   data_byte,
	input  logic [2:0]                   symbol_count,
	input  logic [ncc_pkg::GAP_BITS-1:0] gap_length,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ncc_pkg::OUT_BITS-1:0] count_a,
	output logic [ncc_pkg::OUT_BITS-1:0] count_c,
	output logic [ncc_pkg::OUT_BITS-1:0] count_g,
	output logic [ncc_pkg::OUT_BITS-1:0] count_t,
	output logic [ncc_pkg::OUT_BITS-1:0] count_n,
	output logic [ncc_pkg::OUT_BITS-1:0] count_other,
	output logic [ncc_pkg::OUT_BITS-1:0] gap_total,
	output logic                         starts_with_gap,
	output logic                         ends_with_gap,
	output logic                         has_reference
);

	// wide enough to hold a counter and the output field alike
	localparam int WIDE_BITS = COUNT_BITS > ncc_pkg::OUT_BITS ? COUNT_BITS : ncc_pkg::OUT_BITS;

	ncc_pkg::data_info_t     data_info;
	ncc_pkg::stage_item_t    new_item;
	ncc_pkg::stage_item_t    item_s1;
	logic                    valid_s1;
	logic                    retire;
	logic                    finish_retire;

	logic [COUNT_BITS-1:0]       totals [ncc_pkg::NUM_CLASSES];
	logic [COUNT_BITS-1:0]       gap_sum;
	ncc_pkg::summary_flags_t     flags;
	logic [ncc_pkg::OUT_BITS-1:0] snap [ncc_pkg::NUM_CLASSES];
	logic [ncc_pkg::OUT_BITS-1:0] gap_snap;
	logic [WIDE_BITS-1:0]        gap_wide;

	logic                         out_valid_q;
	logic [ncc_pkg::OUT_BITS-1:0] count_q [ncc_pkg::NUM_CLASSES];
	logic [ncc_pkg::OUT_BITS-1:0] gap_total_q;
	ncc_pkg::summary_flags_t      flags_q;

	// decode lanes and merge, feeding the stage-1 register
	ncc_merge u_merge (
		.encoding     (encoding),
		.data_byte    (data_byte),
		.symbol_count (symbol_count),
		.info         (data_info)
	);

	always_comb begin
		new_item = '0;
		new_item.req = ncc_pkg::req_e_t'(req_type);
		new_item.data = data_info;
		new_item.gap_length = gap_length;
	end

	// data, gap and reference items always drain; a finish item needs a free
	// output register (or one being emptied this cycle)
	assign retire = valid_s1
		&& !(item_s1.req == ncc_pkg::REQ_FINISH && out_valid_q && out_stall);
	assign finish_retire = retire && (item_s1.req == ncc_pkg::REQ_FINISH);
	assign in_stall = valid_s1 && !retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= new_item;
		end
	end

	// stage 2: running totals; a finish item reads them and clears them
	ncc_accum #(
		.COUNT_BITS (COUNT_BITS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.apply   (retire),
		.item    (item_s1),
		.totals  (totals),
		.gap_sum (gap_sum),
		.flags   (flags)
	);

	// report each counter as its low output bits, zero-extended when narrower
	for (genvar k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin : g_snap
		logic [WIDE_BITS-1:0] wide;

		assign wide = WIDE_BITS'(totals[k]);
		assign snap[k] = wide[ncc_pkg::OUT_BITS-1:0];
	end

	assign gap_wide = WIDE_BITS'(gap_sum);
	assign gap_snap = gap_wide[ncc_pkg::OUT_BITS-1:0];

	// output register: holds a summary until the out transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_retire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_retire) begin
			for (int k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin
				count_q[k] <= snap[k];
			end
			gap_total_q <= gap_snap;
			flags_q <= flags;
		end
	end

	assign out_valid = out_valid_q;
	assign count_a = count_q[ncc_pkg::CLS_A];
	assign count_c = count_q[ncc_pkg::CLS_C];
	assign count_g = count_q[ncc_pkg::CLS_G];
	assign count_t = count_q[ncc_pkg::CLS_T];
	assign count_n = count_q[ncc_pkg::CLS_N];
	assign count_other = count_q[ncc_pkg::CLS_OTHER];
	assign gap_total = gap_total_q;
	assign starts_with_gap = flags_q.begins_gap;
	assign ends_with_gap = flags_q.finishes_gap;
	assign has_reference = flags_q.saw_reference;

endmodule

// ----- design/ncc_lane.sv -----
// one decode lane: classifies the code at the top of its byte
module ncc_lane (
	input  logic [1:0]          encoding,
	input  logic                active,
	input  logic [7:0]          code_byte,
	output ncc_pkg::class_hit_t hit
);

	always_comb begin
		hit = '0;
		if (active) begin
			unique case (ncc_pkg::enc_e_t'(encoding))
				ncc_pkg::ENC_TWO: begin
					unique case (code_byte[7:6])
						ncc_pkg::TWO_A: hit[ncc_pkg::CLS_A] = 1'b1;
						ncc_pkg::TWO_C: hit[ncc_pkg::CLS_C] = 1'b1;
						ncc_pkg::TWO_G: hit[ncc_pkg::CLS_G] = 1'b1;
						ncc_pkg::TWO_T: hit[ncc_pkg::CLS_T] = 1'b1;
						default:        hit[ncc_pkg::CLS_T] = 1'b1;
					endcase
				end
				ncc_pkg::ENC_FOUR: begin
					unique case (code_byte[7:4])
						ncc_pkg::NIB_A: hit[ncc_pkg::CLS_A] = 1'b1;
						ncc_pkg::NIB_C: hit[ncc_pkg::CLS_C] = 1'b1;
						ncc_pkg::NIB_G: hit[ncc_pkg::CLS_G] = 1'b1;
						ncc_pkg::NIB_T: hit[ncc_pkg::CLS_T] = 1'b1;
						ncc_pkg::NIB_N: begin
							hit[ncc_pkg::CLS_N] = 1'b1;
							hit[ncc_pkg::CLS_OTHER] = 1'b1;
						end
						default: hit[ncc_pkg::CLS_OTHER] = 1'b1;
					endcase
				end
				ncc_pkg::ENC_IUPAC: begin
					unique case (code_byte)
						ncc_pkg::LETTER_A: hit[ncc_pkg::CLS_A] = 1'b1;
						ncc_pkg::LETTER_C: hit[ncc_pkg::CLS_C] = 1'b1;
						ncc_pkg::LETTER_G: hit[ncc_pkg::CLS_G] = 1'b1;
						ncc_pkg::LETTER_T: hit[ncc_pkg::CLS_T] = 1'b1;
						ncc_pkg::LETTER_N: begin
							hit[ncc_pkg::CLS_N] = 1'b1;
							hit[ncc_pkg::CLS_OTHER] = 1'b1;
						end
						default: hit[ncc_pkg::CLS_OTHER] = 1'b1;
					endcase
				end
				ncc_pkg::ENC_NONE: hit = '0;
				default: hit = '0;
			endcase
		end
	end

endmodule

// ----- design/ncc_merge.sv -----
// splits a data byte over the decode lanes and merges their hits into per-class increments
module ncc_merge (
	input  logic [1:0]          encoding,
	input  logic [7:0]          data_byte,
	input  logic [2:0]          symbol_count,
	output ncc_pkg::data_info_t info
);

	logic [ncc_pkg::NUM_LANES:0] active;
	ncc_pkg::class_hit_t         hit [ncc_pkg::NUM_LANES];
	logic [2:0]                  lane_limit;

	assign lane_limit = ncc_pkg::codes_per_byte(ncc_pkg::enc_e_t'(encoding));
	assign active[ncc_pkg::NUM_LANES] = 1'b0;

	for (genvar l = 0; l < ncc_pkg::NUM_LANES; l++) begin : g_lane
		logic [7:0] lane_byte;

		// lane l sees its code at the most significant end
		assign lane_byte = (ncc_pkg::enc_e_t'(encoding) == ncc_pkg::ENC_FOUR)
			? 8'(data_byte << (4 * l)) : 8'(data_byte << (2 * l));
		assign active[l] = (3'(l) < symbol_count) && (3'(l) < lane_limit);

		ncc_lane u_lane (
			.encoding  (encoding),
			.active    (active[l]),
			.code_byte (lane_byte),
			.hit       (hit[l])
		);
	end

	always_comb begin
		info = '0;
		info.used = active[0];
		info.first_n = hit[0][ncc_pkg::CLS_N];
		for (int l = 0; l < ncc_pkg::NUM_LANES; l++) begin
			for (int k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin
				info.incr[k] = info.incr[k] + ncc_pkg::INCR_BITS'(hit[l][k]);
			end
			// active lanes form a prefix, so the last one has an idle neighbor
			if (active[l] && !active[l + 1]) begin
				info.last_n = hit[l][ncc_pkg::CLS_N];
			end
		end
	end

endmodule

// ----- design/ncc_accum.sv -----
// saturating composition counters, gap total and sequence flags
module ncc_accum #(
	parameter int COUNT_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    apply,
	input  ncc_pkg::stage_item_t    item,
	output logic [COUNT_BITS-1:0]   totals [ncc_pkg::NUM_CLASSES],
	output logic [COUNT_BITS-1:0]   gap_sum,
	output ncc_pkg::summary_flags_t flags
);

	localparam int GAP_SUM_BITS =
		(COUNT_BITS > ncc_pkg::GAP_BITS ? COUNT_BITS : ncc_pkg::GAP_BITS) + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0]   cnt_q [ncc_pkg::NUM_CLASSES];
	logic [COUNT_BITS-1:0]   cnt_next [ncc_pkg::NUM_CLASSES];
	logic [COUNT_BITS-1:0]   gap_q;
	logic [COUNT_BITS-1:0]   gap_next;
	logic [GAP_SUM_BITS-1:0] gap_wide;
	logic                    at_first_q;
	ncc_pkg::summary_flags_t flags_q;

	for (genvar k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin : g_cnt
		logic [COUNT_BITS:0] sum;

		assign sum = {1'b0, cnt_q[k]} + (COUNT_BITS + 1)'(item.data.incr[k]);
		assign cnt_next[k] = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
		assign totals[k] = cnt_q[k];
	end

	assign gap_wide = GAP_SUM_BITS'(gap_q) + GAP_SUM_BITS'(item.gap_length);
	assign gap_next = (gap_wide > GAP_SUM_BITS'(CNT_MAX)) ? CNT_MAX
		: gap_wide[COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin
				cnt_q[k] <= '0;
			end
			gap_q <= '0;
			at_first_q <= 1'b1;
			flags_q <= '0;
		end else if (apply) begin
			unique case (item.req)
				ncc_pkg::REQ_DATA: begin
					for (int k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin
						cnt_q[k] <= cnt_next[k];
					end
					if (item.data.used) begin
						at_first_q <= 1'b0;
						flags_q.finishes_gap <= item.data.last_n;
						if (at_first_q && item.data.first_n) begin
							flags_q.begins_gap <= 1'b1;
						end
					end
				end
				ncc_pkg::REQ_GAP: begin
					gap_q <= gap_next;
					if (at_first_q) begin
						flags_q.begins_gap <= 1'b1;
						at_first_q <= 1'b0;
					end
					flags_q.finishes_gap <= 1'b1;
				end
				ncc_pkg::REQ_REF: begin
					at_first_q <= 1'b0;
					flags_q.finishes_gap <= 1'b0;
					flags_q.saw_reference <= 1'b1;
				end
				ncc_pkg::REQ_FINISH: begin
					for (int k = 0; k < ncc_pkg::NUM_CLASSES; k++) begin
						cnt_q[k] <= '0;
					end
					gap_q <= '0;
					at_first_q <= 1'b1;
					flags_q <= '0;
				end
				default: begin
					at_first_q <= at_first_q;
				end
			endcase
		end
	end

	assign gap_sum = gap_q;
	assign flags = flags_q;

endmodule

// ----- dv/nucleotide_composition_counter_tb.sv -----
// self-checking testbench for the nucleotide composition counter
module nucleotide_composition_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ncc_pkg::*;

	// one segment item as it crosses the input channel
	typedef struct {
		req_e_t      req;
		enc_e_t      enc;
		logic [7:0]  data_byte;
		logic [2:0]  sym_cnt;
		logic [31:0] gap_len;
	} seg_item_t;

	// running composition of the sequence being built
	typedef struct {
		logic [31:0] a, c, g, t, n, oth, gaps;
		logic        at_first, lead_gap, trail_gap, seen_ref;
	} composition_t;

	// one summary as it leaves on the output channel
	typedef struct {
		logic [31:0] a, c, g, t, n, oth, gaps;
		logic        lead_gap, trail_gap, seen_ref;
	} summary_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [1:0]  encoding = '0;
	logic [7:0]  data_byte = '0;
	logic [2:0]  symbol_count = '0;
	logic [31:0] gap_length = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] count_a, count_c, count_g, count_t, count_n, count_other, gap_total;
	logic        starts_with_gap, ends_with_gap, has_reference;

	seg_item_t    segment_q[$];   // items waiting to be driven
	summary_t     summary_q[$];   // summaries predicted but not yet seen
	composition_t tally;          // predicted state of the block
	int           errors = 0;
	int           live_items = 0; // items that actually touch the state

	nucleotide_composition_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.encoding(encoding),
		.data_byte(data_byte),
		.symbol_count(symbol_count),
		.gap_length(gap_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.count_a(count_a),
		.count_c(count_c),
		.count_g(count_g),
		.count_t(count_t),
		.count_n(count_n),
		.count_other(count_other),
		.gap_total(gap_total),
		.starts_with_gap(starts_with_gap),
		.ends_with_gap(ends_with_gap),
		.has_reference(has_reference)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------------

	function automatic composition_t fresh_tally();
		composition_t s;
		s.a = '0; s.c = '0; s.g = '0; s.t = '0;
		s.n = '0; s.oth = '0; s.gaps = '0;
		s.at_first = 1'b1;
		s.lead_gap = 1'b0;
		s.trail_gap = 1'b0;
		s.seen_ref = 1'b0;
		return s;
	endfunction

	// counters stick at all ones instead of wrapping
	function automatic logic [31:0] sat_add(logic [31:0] cur, logic [31:0] inc);
		logic [32:0] sum;
		sum = {1'b0, cur} + {1'b0, inc};
		return sum[32] ? '1 : sum[31:0];
	endfunction

	// an N counts twice and behaves like a gap for the edge flags
	function automatic void mark_n();
		tally.n = sat_add(tally.n, 32'd1);
		tally.oth = sat_add(tally.oth, 32'd1);
		if (tally.at_first)
			tally.lead_gap = 1'b1;
		tally.trail_gap = 1'b1;
	endfunction

	function automatic void fold_item(seg_item_t it);
		int         k;
		logic [1:0] two;
		logic [3:0] nib;
		summary_t   s;
		case (it.req)
			REQ_DATA: begin
				case (it.enc)
					ENC_TWO: begin
						k = (it.sym_cnt > 3'd4) ? 4 : int'(it.sym_cnt);
						for (int i = 0; i < k; i++) begin
							two = it.data_byte[7-2*i -: 2];
							case (two)
								TWO_A:   tally.a = sat_add(tally.a, 32'd1);
								TWO_C:   tally.c = sat_add(tally.c, 32'd1);
								TWO_G:   tally.g = sat_add(tally.g, 32'd1);
								default: tally.t = sat_add(tally.t, 32'd1);
							endcase
						end
						if (k != 0) begin
							tally.at_first = 1'b0;
							tally.trail_gap = 1'b0;
						end
					end
					ENC_FOUR: begin
						k = (it.sym_cnt > 3'd2) ? 2 : int'(it.sym_cnt);
						for (int i = 0; i < k; i++) begin
							nib = (i == 0) ? it.data_byte[7:4] : it.data_byte[3:0];
							tally.trail_gap = 1'b0;
							case (nib)
								NIB_A:   tally.a = sat_add(tally.a, 32'd1);
								NIB_C:   tally.c = sat_add(tally.c, 32'd1);
								NIB_G:   tally.g = sat_add(tally.g, 32'd1);
								NIB_T:   tally.t = sat_add(tally.t, 32'd1);
								NIB_N:   mark_n();
								default: tally.oth = sat_add(tally.oth, 32'd1);
							endcase
							tally.at_first = 1'b0;
						end
					end
					ENC_IUPAC: begin
						if (it.sym_cnt != 3'd0) begin
							tally.trail_gap = 1'b0;
							case (it.data_byte)
								LETTER_A: tally.a = sat_add(tally.a, 32'd1);
								LETTER_C: tally.c = sat_add(tally.c, 32'd1);
								LETTER_G: tally.g = sat_add(tally.g, 32'd1);
								LETTER_T: tally.t = sat_add(tally.t, 32'd1);
								LETTER_N: mark_n();
								default:  tally.oth = sat_add(tally.oth, 32'd1);
							endcase
							tally.at_first = 1'b0;
						end
					end
					default: ; // unsupported encoding leaves the store alone
				endcase
			end
			REQ_GAP: begin
				if (tally.at_first) begin
					tally.lead_gap = 1'b1;
					tally.at_first = 1'b0;
				end
				tally.gaps = sat_add(tally.gaps, it.gap_len);
				tally.trail_gap = 1'b1;
			end
			REQ_REF: begin
				tally.at_first = 1'b0;
				tally.trail_gap = 1'b0;
				tally.seen_ref = 1'b1;
			end
			default: begin
				s.a = tally.a; s.c = tally.c; s.g = tally.g; s.t = tally.t;
				s.n = tally.n; s.oth = tally.oth; s.gaps = tally.gaps;
				s.lead_gap = tally.lead_gap;
				s.trail_gap = tally.trail_gap;
				s.seen_ref = tally.seen_ref;
				summary_q.insert(summary_q.size(), s);
				tally = fresh_tally();
			end
		endcase
	endfunction

	// predict on every input transfer, using the values from before the edge
	always @(posedge clk) begin
		seg_item_t it;
		if (!arst_n) begin
			tally = fresh_tally();
		end else if (in_valid && !in_stall) begin
			it.req = req_e_t'(req_type);
			it.enc = enc_e_t'(encoding);
			it.data_byte = data_byte;
			it.sym_cnt = symbol_count;
			it.gap_len = gap_length;
			fold_item(it);
		end
	end

	// ---------------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------------

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// compare each output transfer with the oldest predicted summary
	always @(posedge clk) begin
		summary_t s;
		if (arst_n && out_valid && !out_stall) begin
			if (summary_q.size() == 0) begin
				$display("%0t ns: summary transfer expected none, got count_a %0h gap_total %0h",
					$time, count_a, gap_total);
				errors++;
			end else begin
				s = summary_q.pop_front();
				check_field("count_a", s.a, count_a);
				check_field("count_c", s.c, count_c);
				check_field("count_g", s.g, count_g);
				check_field("count_t", s.t, count_t);
				check_field("count_n", s.n, count_n);
				check_field("count_other", s.oth, count_other);
				check_field("gap_total", s.gaps, gap_total);
				check_field("starts_with_gap", 32'(s.lead_gap), 32'(starts_with_gap));
				check_field("ends_with_gap", 32'(s.trail_gap), 32'(ends_with_gap));
				check_field("has_reference", 32'(s.seen_ref), 32'(has_reference));
			end
		end
	end

	// ---------------------------------------------------------------------
	// driver: bursts of transfers separated by random idle stretches
	// ---------------------------------------------------------------------

	int burst_left = 0;
	int idle_left = 0;

	always @(posedge clk or negedge arst_n) begin
		seg_item_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			// the slot is free: either nothing was offered or it was just taken
			if (idle_left > 0) begin
				idle_left--;
				in_valid <= 1'b0;
			end else if (segment_q.size() != 0) begin
				cur = segment_q.pop_front();
				req_type <= cur.req;
				encoding <= cur.enc;
				data_byte <= cur.data_byte;
				symbol_count <= cur.sym_cnt;
				gap_length <= cur.gap_len;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					// now and then a long run with no idling at all
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 12);
					idle_left = $urandom_range(1, 5);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern: the mode is redrawn each time stall_phase wraps to zero
	logic [7:0] stall_phase = '0;
	logic [1:0] stall_mode = '0;

	always @(posedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		if (stall_phase == 8'd0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0:    out_stall <= 1'b0;
			2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
			2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_phase[2];
		endcase
	end

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------

	task automatic push_item(req_e_t req, enc_e_t enc, logic [7:0] b, logic [2:0] cnt,
			logic [31:0] glen);
		seg_item_t it;
		it.req = req;
		it.enc = enc;
		it.data_byte = b;
		it.sym_cnt = cnt;
		it.gap_len = glen;
		segment_q.insert(segment_q.size(), it);
		// ignored data items do not count toward the item budget
		if (!(req == REQ_DATA && (enc == ENC_NONE || cnt == 3'd0)))
			live_items++;
	endtask

	function automatic logic [3:0] pick_nibble();
		case ($urandom_range(0, 6))
			0:       return NIB_A;
			1:       return NIB_C;
			2:       return NIB_G;
			3:       return NIB_T;
			4:       return NIB_N;
			default: return 4'($urandom_range(0, 15));
		endcase
	endfunction

	// one data byte with random content, usually well-formed
	task automatic push_base_byte();
		enc_e_t     enc;
		logic [7:0] b;
		logic [2:0] cnt;
		int         r;
		enc = enc_e_t'($urandom_range(0, 2));
		case (enc)
			ENC_TWO: begin
				b = 8'($urandom);
				cnt = 3'($urandom_range(1, 4));
			end
			ENC_FOUR: begin
				b = {pick_nibble(), pick_nibble()};
				cnt = 3'($urandom_range(1, 2));
			end
			default: begin
				case ($urandom_range(0, 9))
					0:       b = LETTER_A;
					1:       b = LETTER_C;
					2:       b = LETTER_G;
					3:       b = LETTER_T;
					4, 5:    b = LETTER_N;
					6:       b = LETTER_A | 8'h20; // lower case is just other
					default: b = 8'($urandom);
				endcase
				cnt = 3'd1;
			end
		endcase
		// occasionally a zero count or one beyond what the byte holds
		r = $urandom_range(0, 15);
		if (r == 0)
			cnt = 3'd0;
		else if (r == 1)
			cnt = 3'($urandom_range(5, 7));
		push_item(REQ_DATA, enc, b, cnt, $urandom);
	endtask

	initial begin
		int body;
		int r;

		// directed part
		push_item(REQ_GAP, ENC_IUPAC, 8'h00, 3'd1, 32'd0);              // zero gap first
		push_item(REQ_DATA, ENC_IUPAC, LETTER_A, 3'd1, '1);
		push_item(REQ_DATA, ENC_IUPAC, LETTER_C, 3'd7, '0);             // count clamped
		push_item(REQ_DATA, ENC_IUPAC, LETTER_G, 3'd0, '0);             // count zero
		push_item(REQ_DATA, ENC_IUPAC, LETTER_T, 3'd4, '0);
		push_item(REQ_DATA, ENC_IUPAC, 8'h61, 3'd1, '0);                // lower-case a
		push_item(REQ_DATA, ENC_IUPAC, 8'hFF, 3'd1, '0);
		push_item(REQ_DATA, ENC_TWO, {TWO_A, TWO_C, TWO_G, TWO_T}, 3'd4, '0);
		push_item(REQ_DATA, ENC_TWO, 8'hFF, 3'd7, '0);
		push_item(REQ_DATA, ENC_FOUR, {NIB_A, NIB_C}, 3'd2, '0);
		push_item(REQ_DATA, ENC_FOUR, {NIB_G, NIB_T}, 3'd6, '0);
		push_item(REQ_DATA, ENC_FOUR, {NIB_N, 4'h0}, 3'd2, '0);         // N then other
		push_item(REQ_DATA, ENC_NONE, LETTER_A, 3'd1, '0);              // ignored
		push_item(REQ_REF, ENC_NONE, 8'hFF, 3'd7, '1);
		push_item(REQ_GAP, ENC_TWO, 8'h00, 3'd0, 32'hFFFF_FFFF);
		push_item(REQ_GAP, ENC_TWO, 8'h00, 3'd0, 32'd5);                // gap total saturates
		push_item(REQ_DATA, ENC_IUPAC, LETTER_N, 3'd1, '0);             // ends on an N
		push_item(REQ_FINISH, ENC_IUPAC, 8'h00, 3'd0, '0);
		push_item(REQ_DATA, ENC_IUPAC, LETTER_N, 3'd1, '0);             // starts on an N
		push_item(REQ_DATA, ENC_FOUR, {NIB_N, 4'h3}, 3'd1, '0);         // first code only
		push_item(REQ_REF, ENC_IUPAC, 8'h00, 3'd0, '0);
		push_item(REQ_GAP, ENC_FOUR, 8'h00, 3'd1, 32'd7);
		push_item(REQ_FINISH, ENC_NONE, 8'hFF, 3'd7, '1);
		push_item(REQ_FINISH, ENC_IUPAC, 8'h00, 3'd0, '0);              // empty sequence

		// random part: mostly whole sequences, with bursts of noise between them
		while (live_items < 1600) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 6))
					push_item(req_e_t'($urandom_range(0, 3)), enc_e_t'($urandom_range(0, 3)),
						8'($urandom), 3'($urandom_range(0, 7)), $urandom);
			end else begin
				// how the sequence opens decides the leading-gap flag
				case ($urandom_range(0, 5))
					0:       push_item(REQ_GAP, enc_e_t'($urandom_range(0, 3)), 8'($urandom),
							3'($urandom_range(0, 7)), 32'($urandom_range(0, 100)));
					1:       push_item(REQ_DATA, ENC_IUPAC, LETTER_N, 3'd1, $urandom);
					2:       push_item(REQ_REF, enc_e_t'($urandom_range(0, 3)), 8'($urandom),
							3'($urandom_range(0, 7)), $urandom);
					default: ;
				endcase
				body = $urandom_range(1, 30);
				repeat (body) begin
					r = $urandom_range(0, 19);
					if (r == 0)
						push_item(REQ_GAP, enc_e_t'($urandom_range(0, 3)), 8'($urandom),
							3'($urandom_range(0, 7)),
							($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100));
					else if (r == 1)
						push_item(REQ_REF, enc_e_t'($urandom_range(0, 3)), 8'($urandom),
							3'($urandom_range(0, 7)), $urandom);
					else
						push_base_byte();
				end
				// how it closes decides the trailing-gap flag
				case ($urandom_range(0, 3))
					0:       push_item(REQ_GAP, ENC_IUPAC, 8'($urandom), 3'd1,
							32'($urandom_range(0, 50)));
					1:       push_item(REQ_DATA, ENC_FOUR, {NIB_N, NIB_N}, 3'd2, $urandom);
					default: ;
				endcase
				push_item(REQ_FINISH, enc_e_t'($urandom_range(0, 3)), 8'($urandom),
					3'($urandom_range(0, 7)), $urandom);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// every item taken, then every summary seen, then a short drain
		wait (segment_q.size() == 0 && !in_valid);
		wait (summary_q.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- nucleotide_composition_counter.f -----
design/ncc_pkg.sv
design/ncc_lane.sv
design/ncc_merge.sv
design/ncc_accum.sv
design/nucleotide_composition_counter.sv
dv/nucleotide_composition_counter_tb.sv
